>>> src/nesmix_pkg.sv
// Shared types and constants for the NES audio mixer, DC blocker and resampler.
// Used by every module of the block; depends on nothing.
`default_nettype none

package nesmix_pkg;

  localparam int PULSE_MAX = 30;
  localparam int TND_MAX   = 202;
  localparam int MIX_W     = 15;

  // Mixer table scale: 16000 / 100 folded into the numerator.
  localparam int PULSE_K = 9588 * 160;
  localparam int PULSE_D = 8128;
  localparam int TND_K   = 16367 * 160;
  localparam int TND_D   = 24329;

  localparam int DC_POLE = 32604;

  localparam int STEP_W = 35;
  localparam int POS_W  = 36;
  localparam int FRAC_W = 16;

  localparam logic [STEP_W-1:0] STEP_RESET = 35'd5919001804;
  localparam logic [STEP_W-1:0] STEP_MIN   = 35'd1073741824;
  localparam logic [POS_W-1:0]  ONE_UNIT   = 36'h1_0000_0000;

  localparam int Q_DEPTH = 2;

  typedef struct packed {
    logic [3:0] pulse_one;
    logic [3:0] pulse_two;
    logic [3:0] triangle_level;
    logic [3:0] noise_level;
    logic [6:0] dmc_level;
  } mix_in_t;

  typedef struct packed {
    logic signed [15:0] out_sample;
    logic               last_of_run;
  } mix_out_t;

  typedef struct packed {
    logic               load_only;
    logic signed [15:0] sample;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_port_t;

  typedef struct packed {
    logic              en;
    logic [STEP_W-1:0] step;
  } cfg_wr_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } bk_state_e;

endpackage

`default_nettype wire

>>> src/nes_audio_mix_dc_block_resample.sv
// Top level of the NES audio mixer with DC blocker and linear resampler.
// Instantiates nesmix_front, nesmix_queue and nesmix_back; uses nesmix_pkg.
//
// Each input carries the five channel DAC levels and yields zero to four
// interpolated 16-bit samples, the last one flagged by last_of_run. The front
// end takes no new input while it is busy with the last one or while the
// queue is full: it registers the table lookup and the feedback multiply,
// then does the DC blocker update in the next cycle and pushes the sample.
// Samples wait in a two-entry queue. The back end takes a sample, starts an
// interpolation multiply for each output and emits one output per cycle
// while the output side keeps up, then closes the run with a final step
// before it takes the next sample. The first input after reset or after a
// step write only primes the interpolator. The step register is written
// through the configuration channel, which is always ready; a write also
// restarts the resampler position.
`default_nettype none

module nes_audio_mix_dc_block_resample import nesmix_pkg::*; #(
  parameter int QueueDepth = Q_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire mix_in_t           in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output mix_out_t               out_data_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [STEP_W-1:0] cfg_data_i
);

  cfg_wr_t cfg;
  q_port_t push, head;
  logic    q_full, pop;

  assign cfg_ready_o = 1'b1;
  assign cfg.en      = cfg_valid_i && cfg_ready_o;
  assign cfg.step    = cfg_data_i;

  nesmix_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg),
    .q_full_i   (q_full),
    .push_o     (push)
  );

  nesmix_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .head_o (head),
    .pop_i  (pop)
  );

  nesmix_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> src/nesmix_front.sv
// Front end: channel mixing through the nonlinear tables and the DC blocker.
// Uses nesmix_pkg; pushes tagged samples into the queue.
`default_nettype none

module nesmix_front import nesmix_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire mix_in_t in_data_i,
  input  wire cfg_wr_t cfg_i,
  input  wire logic    q_full_i,
  output q_port_t      push_o
);

  logic [MIX_W-1:0] pulse_rom [PULSE_MAX+1];
  logic [MIX_W-1:0] tnd_rom   [TND_MAX+1];

  for (genvar gi = 0; gi <= PULSE_MAX; gi++) begin : g_pulse_rom
    localparam int Val = PULSE_K * gi / (PULSE_D + 100 * gi);
    assign pulse_rom[gi] = MIX_W'(Val);
  end

  for (genvar gi = 0; gi <= TND_MAX; gi++) begin : g_tnd_rom
    localparam int Val = TND_K * gi / (TND_D + 100 * gi);
    assign tnd_rom[gi] = MIX_W'(Val);
  end

  logic                    busy_q;
  logic                    have_prev_q;
  logic [MIX_W-1:0]        x_q, x_d;
  logic [MIX_W-1:0]        xprev_q;
  logic signed [15:0]      yprev_q;
  logic signed [31:0]      prod_q, prod_d;
  logic [4:0]              psum_raw, psum;
  logic [7:0]              tsum_raw, tsum;
  logic signed [31:0]      yprev_ext, pole_ext;
  logic signed [18:0]      y_wide;
  logic signed [15:0]      y_sat;
  logic                    accept;

  assign in_stall_o = busy_q || q_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    psum_raw = 5'(in_data_i.pulse_one) + 5'(in_data_i.pulse_two);
    psum     = (psum_raw > 5'(PULSE_MAX)) ? 5'(PULSE_MAX) : psum_raw;
    tsum_raw = 8'(3 * in_data_i.triangle_level) + 8'(2 * in_data_i.noise_level)
             + 8'(in_data_i.dmc_level);
    tsum     = (tsum_raw > 8'(TND_MAX)) ? 8'(TND_MAX) : tsum_raw;
    x_d      = pulse_rom[psum] + tnd_rom[tsum];
    yprev_ext = 32'(yprev_q);
    pole_ext  = 32'(DC_POLE);
    prod_d    = yprev_ext * pole_ext;
  end

  always_comb begin
    y_wide = $signed({4'b0, x_q}) - $signed({4'b0, xprev_q}) + 19'(prod_q >>> 15);
    if (y_wide > 19'sd32767) begin
      y_sat = 16'sh7fff;
    end else if (y_wide < -19'sd32768) begin
      y_sat = 16'sh8000;
    end else begin
      y_sat = y_wide[15:0];
    end
  end

  assign push_o.valid           = busy_q;
  assign push_o.entry.load_only = !have_prev_q;
  assign push_o.entry.sample    = y_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      have_prev_q <= 1'b0;
      xprev_q     <= '0;
      yprev_q     <= '0;
    end else begin
      busy_q <= accept;
      if (busy_q) begin
        xprev_q     <= x_q;
        yprev_q     <= y_sat;
        have_prev_q <= 1'b1;
      end
      if (cfg_i.en) begin
        have_prev_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q    <= x_d;
      prod_q <= prod_d;
    end
  end

endmodule

`default_nettype wire

>>> src/nesmix_queue.sv
// Small FIFO of DC-blocked samples between the front and back ends.
// Uses nesmix_pkg for the entry type.
`default_nettype none

module nesmix_queue import nesmix_pkg::*; #(
  parameter int Depth = Q_DEPTH
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire q_port_t push_i,
  output logic         full_o,
  output q_port_t      head_o,
  input  wire logic    pop_i
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  q_entry_t        mem [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_o.valid = (count_q != '0);
  assign head_o.entry = mem[rd_ptr_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    next_ptr = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= push_i.entry;
    end
  end

endmodule

`default_nettype wire

>>> src/nesmix_back.sv
// Back end: linear-interpolating resampler with its output register.
// Uses nesmix_pkg; pops samples from the queue.
`default_nettype none

module nesmix_back import nesmix_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire cfg_wr_t cfg_i,
  input  wire q_port_t head_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output mix_out_t     out_data_o
);

  bk_state_e          state_q, state_d;
  logic [STEP_W-1:0]  step_q, eff_step;
  logic [POS_W-1:0]   pos_q, pos_next;
  logic signed [15:0] prev_q, cur_q;
  logic signed [16:0] diff_q, diff_d;
  logic signed [33:0] prod_q, prod_d, diff_ext, frac_ext;
  logic               pv_q, plast_q;
  logic               out_valid_q;
  mix_out_t           out_q;
  logic               slot_free, emit, issue, finish, pos_done, last_d;
  logic signed [17:0] interp;

  assign eff_step = (step_q < STEP_MIN) ? STEP_MIN : step_q;
  assign pos_next = pos_q + POS_W'(eff_step);
  assign pos_done = (pos_q >= ONE_UNIT);
  assign last_d   = (pos_next >= ONE_UNIT);
  assign diff_d   = 17'(head_i.entry.sample) - 17'(prev_q);
  assign diff_ext = 34'(diff_q);
  assign frac_ext = $signed({18'b0, pos_q[31:16]});
  assign prod_d   = diff_ext * frac_ext;
  assign interp   = 18'(prev_q) + $signed(prod_q[33:16]);

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    pop_o  = 1'b0;
    emit   = 1'b0;
    issue  = 1'b0;
    finish = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        pop_o = head_i.valid;
      end
      BK_RUN: begin
        emit   = pv_q && slot_free;
        issue  = (!pv_q || emit) && !pos_done;
        finish = !pv_q && pos_done;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (head_i.valid && !head_i.entry.load_only) begin
          state_d = BK_RUN;
        end
      end
      BK_RUN: begin
        if (finish) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      step_q      <= STEP_RESET;
      pos_q       <= '0;
      prev_q      <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o && head_i.entry.load_only) begin
        prev_q <= head_i.entry.sample;
      end
      if (issue) begin
        pos_q <= pos_next;
        pv_q  <= 1'b1;
      end else if (emit) begin
        pv_q <= 1'b0;
      end
      if (finish) begin
        pos_q  <= pos_q - ONE_UNIT;
        prev_q <= cur_q;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.en) begin
        step_q <= cfg_i.step;
        pos_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q  <= head_i.entry.sample;
      diff_q <= diff_d;
    end
    if (issue) begin
      prod_q  <= prod_d;
      plast_q <= last_d;
    end
    if (emit) begin
      out_q.out_sample  <= interp[15:0];
      out_q.last_of_run <= plast_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> src/nesmix_checker.sv
// Port-level checks for the NES audio mixer top level, attached by bind.
// Uses nesmix_pkg for the port types.
`default_nettype none

module nesmix_checker import nesmix_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire mix_in_t           in_data_i,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire mix_out_t          out_data_o,
  input wire logic              cfg_valid_i,
  input wire logic              cfg_ready_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output changed");

  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input request changed");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input accepted on consecutive cycles");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_acc))
    else $error("input stall rose without an accepted input");

  a_cfg_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration port lost readiness");

endmodule

bind nes_audio_mix_dc_block_resample nesmix_checker u_checker (.*);

`default_nettype wire

>>> test/tb_nes_audio_mix_dc_block_resample.sv
// Self-checking testbench for nes_audio_mix_dc_block_resample.
// Drives channel levels and step writes, predicts mixed, DC-blocked, resampled
// samples in place and compares every output; depends on nesmix_pkg and the RTL.
`default_nettype none

module tb_nes_audio_mix_dc_block_resample;
  import nesmix_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     DRAIN_CYCLES = 32;
  localparam int     CYCLE_LIMIT  = 400000;
  localparam longint POS_MASK     = 64'hF_FFFF_FFFF;
  localparam int     IN_W         = $bits(mix_in_t);

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  mix_in_t           in_data_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  mix_out_t          out_data_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [STEP_W-1:0] cfg_data_i  = '0;

  nes_audio_mix_dc_block_resample DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  mix_out_t          expected_samples[$];
  int                error_count = 0;
  int                cycle_count = 0;
  bit                idle_off    = 1'b0;
  int                stall_left  = 0;

  longint            dc_x_prev   = 0;
  longint            dc_y_prev   = 0;
  longint            held_sample = 0;
  bit                held_valid  = 1'b0;
  longint            res_pos     = 0;
  logic [STEP_W-1:0] res_step    = STEP_RESET;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  function automatic longint pulse_level(input longint i);
    return (64'd9588 * i * 64'd16000) / (64'd100 * (64'd8128 + 64'd100 * i));
  endfunction

  function automatic longint tnd_level(input longint i);
    return (64'd16367 * i * 64'd16000) / (64'd100 * (64'd24329 + 64'd100 * i));
  endfunction

  task automatic predict_samples(input mix_in_t s);
    longint   psum;
    longint   tsum;
    longint   x;
    longint   y;
    longint   pos;
    longint   stp;
    longint   frac;
    longint   v;
    int       n;
    mix_out_t r;
    psum = longint'(s.pulse_one) + longint'(s.pulse_two);
    if (psum > PULSE_MAX) psum = PULSE_MAX;
    tsum = 3 * longint'(s.triangle_level) + 2 * longint'(s.noise_level) +
           longint'(s.dmc_level);
    if (tsum > TND_MAX) tsum = TND_MAX;
    x = pulse_level(psum) + tnd_level(tsum);
    y = x - dc_x_prev + ((dc_y_prev * 32604) >>> 15);
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    dc_x_prev = x;
    dc_y_prev = y;
    if (!held_valid) begin
      held_sample = y;
      held_valid  = 1'b1;
      return;
    end
    stp = longint'(res_step);
    if (stp < longint'(STEP_MIN)) stp = longint'(STEP_MIN);
    pos = res_pos;
    n   = 0;
    while (pos < longint'(ONE_UNIT) && n < 4) begin
      frac = (pos >> 16) & 64'hFFFF;
      v = held_sample + (((y - held_sample) * frac) >>> 16);
      pos += stp;
      n++;
      r.out_sample  = v[15:0];
      r.last_of_run = !(pos < longint'(ONE_UNIT) && n < 4);
      expected_samples.push_back(r);
    end
    res_pos     = (pos - longint'(ONE_UNIT)) & POS_MASK;
    held_sample = y;
  endtask

  task automatic send_levels(input mix_in_t s);
    int gap;
    gap = idle_off ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_samples(s);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_step(input logic [STEP_W-1:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    res_step   = value;
    res_pos    = 0;
    held_valid = 1'b0;
  endtask

  function automatic mix_in_t levels(input int p1, p2, tri_l, noi, dmc);
    mix_in_t s;
    s.pulse_one      = p1[3:0];
    s.pulse_two      = p2[3:0];
    s.triangle_level = tri_l[3:0];
    s.noise_level    = noi[3:0];
    s.dmc_level      = dmc[6:0];
    return s;
  endfunction

  function automatic mix_in_t random_levels();
    mix_in_t s;
    if ($urandom_range(0, 9) < 3) begin
      s.pulse_one      = {4{$urandom_range(0, 1) == 1}};
      s.pulse_two      = {4{$urandom_range(0, 1) == 1}};
      s.triangle_level = {4{$urandom_range(0, 1) == 1}};
      s.noise_level    = {4{$urandom_range(0, 1) == 1}};
      s.dmc_level      = {7{$urandom_range(0, 1) == 1}};
    end else begin
      s = mix_in_t'(IN_W'($urandom));
    end
    return s;
  endfunction

  task automatic test_level_extremes();
    send_levels(levels(0, 0, 0, 0, 0));
    send_levels(levels(15, 15, 15, 15, 127));
    send_levels(levels(15, 15, 15, 15, 127));
    send_levels(levels(0, 0, 0, 0, 0));
    send_levels(levels(15, 15, 0, 0, 0));
    send_levels(levels(0, 0, 15, 15, 127));
    send_levels(levels(0, 0, 0, 0, 127));
    send_levels(levels(1, 2, 4, 8, 64));
    wait_drained();
  endtask

  task automatic test_step_bounds();
    write_step('0);
    repeat (4) send_levels(random_levels());
    write_step(STEP_MIN - 1);
    repeat (3) send_levels(random_levels());
    write_step(STEP_MIN);
    repeat (3) send_levels(random_levels());
    write_step({STEP_W{1'b1}});
    repeat (6) send_levels(random_levels());
    wait_drained();
  endtask

  task automatic test_random_streams();
    logic [STEP_W-1:0] value;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: value = {3'b000, $urandom} + {3'b001, 32'h0};
        1: value = {3'($urandom_range(0, 7)), $urandom};
        2: value = {3'b000, $urandom_range(0, 32'h3FFF_FFFF)};
        default: value = STEP_RESET;
      endcase
      write_step(value);
      idle_off = (phase == 3);
      for (int i = 0; i < 25; i++) begin
        send_levels(random_levels());
        if ($urandom_range(0, 19) == 0) wait_drained();
      end
      idle_off = 1'b0;
    end
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    int n;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      n = idle_off ? 0 : $urandom_range(0, 3);
      stall_left  <= n;
      out_stall_i <= (n != 0);
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= (stall_left > 1);
    end
  end

  always @(posedge clk_i) begin
    mix_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("unexpected output sample %0d", out_data_o.out_sample));
      end else begin
        want = expected_samples.pop_front();
        if (out_data_o.out_sample !== want.out_sample)
          report_mismatch($sformatf("out_sample %0d, expected %0d",
                                    out_data_o.out_sample, want.out_sample));
        if (out_data_o.last_of_run !== want.last_of_run)
          report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                    out_data_o.last_of_run, want.last_of_run));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d requests outstanding",
               cycle_count, expected_samples.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_level_extremes();
    test_step_bounds();
    test_random_streams();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
